FILE: sv/bsfr_pkg.sv
// bsfr_pkg: shared types, constants and codes for the byte-stuffed frame receiver
// no dependencies; compile first
package bsfr_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 6;
    localparam int CFG_IDX_W       = 8;

    // request kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MARKER = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 8'd3;

    // register reset values
    localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] END_MARKER_RST    = 8'd3;
    localparam logic [BYTE_W-1:0] ESCAPE_MARKER_RST = 8'd16;
    localparam logic [BYTE_W-1:0] TIMEOUT_TICKS_RST = 8'd10;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_NORMAL  = 4'b0010,
        MODE_ESCAPED = 4'b0100,
        MODE_ENDED   = 4'b1000
    } rx_mode_t;

    typedef enum logic [1:0] {
        DR_IDLE = 2'b01,
        DR_RUN  = 2'b10
    } drain_state_t;

    // framer -> drain sequencer: start of a delivery run
    typedef struct packed {
        logic              go;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] frames;
    } launch_t;

endpackage

FILE: sv/bsfr_if.sv
// bsfr_if: valid/ready channel interfaces for requests, results and register writes
// depends on bsfr_pkg for field widths
interface bsfr_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [bsfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface bsfr_out_if;
    logic                      valid;
    logic                      ready;
    logic [bsfr_pkg::BYTE_W-1:0] payload_byte;
    logic                      last_of_frame;
    logic [bsfr_pkg::LEN_W-1:0]  payload_length;
    logic [bsfr_pkg::BYTE_W-1:0] frames_delivered;

    modport source (output valid, output payload_byte, output last_of_frame,
                    output payload_length, output frames_delivered, input ready);
    modport sink   (input valid, input payload_byte, input last_of_frame,
                    input payload_length, input frames_delivered, output ready);
endinterface

interface bsfr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bsfr_pkg::CFG_IDX_W-1:0] index;
    logic [bsfr_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/byte_stuffed_frame_receiver.sv
// byte and tick requests are taken whenever no run drains; a delivering tick starts a
// run whose first byte is read through the store's registered read port and presented
// from the output register, then one byte per cycle while frame_out.ready is high
// no request is taken on byte_in while a run drains; register writes are always taken
// reset: registers to defaults, mode idle, timer, fill count and frame count zero;
// the frame store is not cleared and needs no clearing pass
module byte_stuffed_frame_receiver #(
    parameter int STORE_DEPTH = bsfr_pkg::STORE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bsfr_in_if.sink    byte_in,
    bsfr_cfg_if.sink   cfg,
    bsfr_out_if.source frame_out
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic                        busy;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [bsfr_pkg::BYTE_W-1:0] wdata;
    logic                        re;
    logic [AW-1:0]               raddr;
    logic [bsfr_pkg::BYTE_W-1:0] rdata;
    bsfr_pkg::launch_t           launch;

    bsfr_framer #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .cfg     (cfg),
        .busy    (busy),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .launch  (launch)
    );

    bsfr_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    bsfr_drain #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .launch    (launch),
        .busy      (busy),
        .re        (re),
        .raddr     (raddr),
        .rdata     (rdata),
        .frame_out (frame_out)
    );

endmodule

FILE: sv/bsfr_store.sv
// bsfr_store: frame byte memory, one write port and one registered read port
// depends on bsfr_pkg for the byte width
module bsfr_store #(
    parameter int STORE_DEPTH = bsfr_pkg::STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [bsfr_pkg::BYTE_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [bsfr_pkg::BYTE_W-1:0] rdata
);

    logic [bsfr_pkg::BYTE_W-1:0] mem [STORE_DEPTH];
    logic [bsfr_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/bsfr_framer.sv
// bsfr_framer: registers, framing mode, silence timer, store fill and frame count
// depends on bsfr_pkg and bsfr_if; writes bytes into bsfr_store
module bsfr_framer #(
    parameter int STORE_DEPTH = bsfr_pkg::STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bsfr_in_if.sink                     byte_in,
    bsfr_cfg_if.sink                    cfg,
    input  logic                        busy,
    output logic                        we,
    output logic [AW-1:0]               waddr,
    output logic [bsfr_pkg::BYTE_W-1:0] wdata,
    output bsfr_pkg::launch_t           launch
);

    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic [bsfr_pkg::BYTE_W-1:0] start_marker_reg, end_marker_reg;
    logic [bsfr_pkg::BYTE_W-1:0] escape_marker_reg, timeout_ticks_reg;

    bsfr_pkg::rx_mode_t          mode_reg, mode_next;
    logic [bsfr_pkg::BYTE_W-1:0] timer_reg, timer_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [bsfr_pkg::BYTE_W-1:0] frames_reg, frames_next;

    logic                        acc;
    logic [bsfr_pkg::BYTE_W-1:0] b;

    assign cfg.ready     = 1'b1;
    assign byte_in.ready = ~busy;
    assign acc           = byte_in.valid & byte_in.ready;
    assign b             = byte_in.rx_byte;
    assign wdata         = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg  <= bsfr_pkg::START_MARKER_RST;
            end_marker_reg    <= bsfr_pkg::END_MARKER_RST;
            escape_marker_reg <= bsfr_pkg::ESCAPE_MARKER_RST;
            timeout_ticks_reg <= bsfr_pkg::TIMEOUT_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bsfr_pkg::REG_START_MARKER:  start_marker_reg  <= cfg.data;
                bsfr_pkg::REG_END_MARKER:    end_marker_reg    <= cfg.data;
                bsfr_pkg::REG_ESCAPE_MARKER: escape_marker_reg <= cfg.data;
                bsfr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        timer_next  = timer_reg;
        count_next  = count_reg;
        frames_next = frames_reg;
        we          = 1'b0;
        waddr       = count_reg[AW-1:0];
        launch      = '0;

        if (acc && byte_in.cmd == bsfr_pkg::CMD_BYTE)
        begin
            if (timer_reg == '0 && b == start_marker_reg)
            begin
                // frame restarts with the start byte at entry 0
                we         = 1'b1;
                waddr      = '0;
                count_next = CW'(1);
                timer_next = timeout_ticks_reg;
                mode_next  = bsfr_pkg::MODE_NORMAL;
            end
            else
            begin
                case (mode_reg)
                    bsfr_pkg::MODE_NORMAL:
                    begin
                        timer_next = timeout_ticks_reg;
                        if (b == escape_marker_reg)
                        begin
                            mode_next = bsfr_pkg::MODE_ESCAPED;
                        end
                        else
                        begin
                            if (count_reg < CW'(STORE_DEPTH))
                            begin
                                we         = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            if (b == end_marker_reg)
                            begin
                                mode_next = bsfr_pkg::MODE_ENDED;
                            end
                        end
                    end
                    bsfr_pkg::MODE_ESCAPED:
                    begin
                        timer_next = timeout_ticks_reg;
                        if (count_reg < CW'(STORE_DEPTH))
                        begin
                            we         = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        mode_next = bsfr_pkg::MODE_NORMAL;
                    end
                    default: ;
                endcase
            end
        end
        else if (acc)
        begin
            if (timer_reg != '0)
            begin
                timer_next = timer_reg - 8'd1;
            end
            else if (mode_reg == bsfr_pkg::MODE_ENDED)
            begin
                mode_next = bsfr_pkg::MODE_IDLE;
                if (count_reg > CW'(2))
                begin
                    frames_next   = frames_reg + 8'd1;
                    launch.go     = 1'b1;
                    launch.len    = bsfr_pkg::LEN_W'(count_reg - CW'(2));
                    launch.frames = frames_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= bsfr_pkg::MODE_IDLE;
            timer_reg  <= '0;
            count_reg  <= '0;
            frames_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            timer_reg  <= timer_next;
            count_reg  <= count_next;
            frames_reg <= frames_next;
        end
    end

endmodule

FILE: sv/bsfr_drain.sv
// bsfr_drain: reads a frame from bsfr_store, presents one byte a cycle unless stalled
// depends on bsfr_pkg and bsfr_if
module bsfr_drain #(
    parameter int STORE_DEPTH = bsfr_pkg::STORE_DEPTH_DEF,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsfr_pkg::launch_t           launch,
    output logic                        busy,
    output logic                        re,
    output logic [AW-1:0]               raddr,
    input  logic [bsfr_pkg::BYTE_W-1:0] rdata,
    bsfr_out_if.source                  frame_out
);

    bsfr_pkg::drain_state_t      state_reg, state_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [AW-1:0]               end_reg, end_next;
    logic                        issuing_reg, issuing_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic                        rd_last_reg, rd_last_next;
    logic                        o_valid_reg, o_valid_next;
    logic [bsfr_pkg::BYTE_W-1:0] o_byte_reg, o_byte_next;
    logic                        o_last_reg, o_last_next;
    logic [bsfr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [bsfr_pkg::BYTE_W-1:0] frames_reg, frames_next;
    logic                        move;

    assign busy  = (state_reg == bsfr_pkg::DR_RUN);
    assign raddr = idx_reg;

    // read stage advances into the output register when that is free or leaving
    assign move = rd_vld_reg & (~o_valid_reg | frame_out.ready);
    assign re   = busy & issuing_reg & (~rd_vld_reg | move);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        end_next     = end_reg;
        issuing_next = issuing_reg;
        rd_vld_next  = rd_vld_reg;
        rd_last_next = rd_last_reg;
        o_valid_next = o_valid_reg;
        o_byte_next  = o_byte_reg;
        o_last_next  = o_last_reg;
        len_next     = len_reg;
        frames_next  = frames_reg;

        case (state_reg)
            bsfr_pkg::DR_IDLE:
            begin
                if (launch.go)
                begin
                    state_next   = bsfr_pkg::DR_RUN;
                    idx_next     = AW'(1);
                    end_next     = AW'(launch.len);
                    issuing_next = 1'b1;
                    len_next     = launch.len;
                    frames_next  = launch.frames;
                end
            end
            bsfr_pkg::DR_RUN:
            begin
                if (re)
                begin
                    rd_vld_next  = 1'b1;
                    rd_last_next = (idx_reg == end_reg);
                    idx_next     = idx_reg + AW'(1);
                    if (idx_reg == end_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                else if (move)
                begin
                    rd_vld_next = 1'b0;
                end

                if (move)
                begin
                    o_valid_next = 1'b1;
                    o_byte_next  = rdata;
                    o_last_next  = rd_last_reg;
                end
                else if (frame_out.ready)
                begin
                    o_valid_next = 1'b0;
                end

                if (o_valid_reg && frame_out.ready && o_last_reg)
                begin
                    state_next = bsfr_pkg::DR_IDLE;
                end
            end
            default:
            begin
                state_next = bsfr_pkg::DR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bsfr_pkg::DR_IDLE;
            issuing_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            rd_vld_reg  <= rd_vld_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        end_reg     <= end_next;
        rd_last_reg <= rd_last_next;
        o_byte_reg  <= o_byte_next;
        o_last_reg  <= o_last_next;
        len_reg     <= len_next;
        frames_reg  <= frames_next;
    end

    assign frame_out.valid            = o_valid_reg;
    assign frame_out.payload_byte     = o_byte_reg;
    assign frame_out.last_of_frame    = o_last_reg;
    assign frame_out.payload_length   = len_reg;
    assign frame_out.frames_delivered = frames_reg;

endmodule

FILE: sv/bsfr_checker.sv
// bsfr_checker: port-level checks on the frame receiver, bound to the top level
// depends on bsfr_pkg and byte_stuffed_frame_receiver
module bsfr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bsfr_pkg::BYTE_W-1:0] out_byte,
    input logic                        out_last,
    input logic [bsfr_pkg::LEN_W-1:0]  out_len,
    input logic [bsfr_pkg::BYTE_W-1:0] out_frames
);

    // no request is taken while a run is being presented
    a_no_accept_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("byte_in ready while a result is pending");

    // a stalled result holds
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("result changed while stalled");

    // bytes of one run follow back to back with the same frame fields
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=>
            out_valid && $stable(out_len) && $stable(out_frames))
        else $error("run broke before its last byte");

    // the input side reopens right after the last byte leaves
    a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> in_ready && !out_valid)
        else $error("input not reopened after end of run");

endmodule

bind byte_stuffed_frame_receiver bsfr_checker u_bsfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (byte_in.ready),
    .out_valid  (frame_out.valid),
    .out_ready  (frame_out.ready),
    .out_byte   (frame_out.payload_byte),
    .out_last   (frame_out.last_of_frame),
    .out_len    (frame_out.payload_length),
    .out_frames (frame_out.frames_delivered)
);
